### design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared codes, types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    // Request opcodes on the input side
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    // Configuration port
    localparam int          ADDR_W        = 3;
    localparam int          DATA_W        = 32;
    localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       first;
        logic       last;
        logic       dropped_before;
    } res_t;

endpackage

### design/length_prefix_deframer_timeout_core.sv
// A request waits in the command queue until the frame logic takes it; its
// result, if any, is then written into the result queue behind the result ports.
// Throughput: one request per cycle while the result queue has room.
// Reset: queues empty, no partial frame, idle count zero, timeout 100 ticks.
// ----------------------------------------------------------------------------
// length_prefix_deframer_timeout_core
// Cut-through length-prefix deframer with inter-byte timeout and flush.
// ----------------------------------------------------------------------------
module length_prefix_deframer_timeout_core
    import lpd_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    // Input queue side
    input  logic              push,
    output logic              full,
    input  logic [1:0]        op,
    input  logic [7:0]        data,
    // Result queue side
    output logic              empty,
    input  logic              pop,
    output logic              kind,
    output logic [7:0]        byte_value,
    output logic              first,
    output logic              last,
    output logic              dropped_before,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [15:0] timeout_reg;
    logic        cmd_pop;
    logic        cmd_empty;
    cmd_t        cmd;
    res_t        res;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_TIMEOUT))
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TIMEOUT)
        begin
            prdata = {{(DATA_W - 16){1'b0}}, timeout_reg};
        end
    end

    lpd_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .data      (data),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    lpd_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .cmd_empty     (cmd_empty),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .res_pop       (pop),
        .res_empty     (empty),
        .res           (res)
    );

    assign kind           = res.kind;
    assign byte_value     = res.byte_value;
    assign first          = res.first;
    assign last           = res.last;
    assign dropped_before = res.dropped_before;

endmodule

### design/lpd_fifo.sv
// ----------------------------------------------------------------------------
// lpd_fifo
// Small flip-flop queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### design/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// Accepts input requests, drops reserved opcodes and queues the rest.
// ----------------------------------------------------------------------------
module lpd_front
    import lpd_pkg::*;
#(
    parameter int CMD_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] op,
    input  logic [7:0] data,
    input  logic       cmd_pop,
    output logic       cmd_empty,
    output cmd_t       cmd
);

    cmd_t cmd_in;
    logic q_push;
    logic q_full;

    // Reserved opcode has no effect: accept and drop it here
    assign q_push = push && (op != OP_RSVD);
    assign full   = q_full;

    always_comb
    begin
        cmd_in.op   = op;
        cmd_in.data = (op == OP_BYTE) ? data : 8'd0;
    end

    lpd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmd_empty)
    );

endmodule

### design/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back
// Frame state machine: tracks length, idle time and timeout; queues results.
// ----------------------------------------------------------------------------
module lpd_back
    import lpd_pkg::*;
#(
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] timeout_ticks,
    input  logic        cmd_empty,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic        res_pop,
    output logic        res_empty,
    output res_t        res
);

    logic [7:0]  bytes_remaining_reg, bytes_remaining_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    res_t        res_in;
    logic        needs_res;
    logic        res_push;
    logic        res_full;
    logic        timed_out;
    logic [7:0]  rem_dec;

    assign timed_out = in_frame_reg && (idle_ticks_reg > timeout_ticks);
    assign rem_dec   = bytes_remaining_reg - 8'd1;

    always_comb
    begin
        needs_res = 1'b0;
        unique case (cmd.op)
            OP_BYTE:  needs_res = 1'b1;
            OP_FLUSH: needs_res = in_frame_reg;
            default:  needs_res = 1'b0;
        endcase
    end

    // Advance only when the result, if any, has room
    assign cmd_pop  = !cmd_empty && (!needs_res || !res_full);
    assign res_push = cmd_pop && needs_res;

    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        in_frame_next        = in_frame_reg;
        idle_ticks_next      = idle_ticks_reg;
        res_in.kind           = KIND_BYTE;
        res_in.byte_value     = cmd.data;
        res_in.first          = 1'b0;
        res_in.last           = 1'b0;
        res_in.dropped_before = 1'b0;
        unique case (cmd.op)
            OP_BYTE:
            begin
                idle_ticks_next       = '0;
                res_in.dropped_before = timed_out;
                if (!in_frame_reg || timed_out)
                begin
                    // Length byte opens a new frame
                    res_in.first = 1'b1;
                    if (cmd.data == 8'd0)
                    begin
                        res_in.last          = 1'b1;
                        in_frame_next        = 1'b0;
                        bytes_remaining_next = timed_out ? 8'd0 : bytes_remaining_reg;
                    end
                    else
                    begin
                        in_frame_next        = 1'b1;
                        bytes_remaining_next = cmd.data;
                    end
                end
                else
                begin
                    bytes_remaining_next = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        res_in.last   = 1'b1;
                        in_frame_next = 1'b0;
                    end
                end
            end
            OP_TICK:
            begin
                if (idle_ticks_reg != IDLE_MAX)
                begin
                    idle_ticks_next = idle_ticks_reg + 16'd1;
                end
            end
            OP_FLUSH:
            begin
                // Drop partial frame and report abort
                in_frame_next         = 1'b0;
                bytes_remaining_next  = in_frame_reg ? 8'd0 : bytes_remaining_reg;
                res_in.kind           = KIND_ABORT;
                res_in.byte_value     = 8'd0;
                res_in.dropped_before = 1'b1;
            end
            default:
            begin
                idle_ticks_next = idle_ticks_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= '0;
            in_frame_reg        <= 1'b0;
            idle_ticks_reg      <= '0;
        end
        else if (cmd_pop)
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            in_frame_reg        <= in_frame_next;
            idle_ticks_reg      <= idle_ticks_next;
        end
    end

    lpd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (res_pop),
        .dout  (res),
        .empty (res_empty)
    );

    a_frame_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_remaining_reg != 8'd0))
        else $error("open frame with no bytes remaining");

    a_abort_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_in.kind == KIND_ABORT)) |-> in_frame_reg)
        else $error("abort issued with no partial frame");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd.op == OP_BYTE)) |=> (idle_ticks_reg == 16'd0))
        else $error("idle count not cleared by byte");

endmodule

### dv/deframe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the request, result and register ports of the deframer, predicts
// the result of every accepted request and compares each popped result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module deframe_checker
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [1:0]        op,
    input  logic [7:0]        data,
    input  logic              empty,
    input  logic              pop,
    input  logic              kind,
    input  logic [7:0]        byte_value,
    input  logic              first,
    input  logic              last,
    input  logic              dropped_before,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatch_count,
    output int                pending
);

    // Own copy of the frame state and the timeout register
    logic [15:0] timeout_cfg;
    logic [7:0]  frame_left;
    logic        frame_open;
    logic [15:0] idle_count;

    res_t        frame_res_q[$];
    res_t        want;
    res_t        got;
    res_t        predicted;
    cmd_t        req;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 200)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Advance the frame state by one request; returns 1 when a result is due
    function automatic bit predict_deframe(input cmd_t c, output res_t r);
        r = '0;
        case (c.op)
            OP_BYTE:
            begin
                r.kind       = KIND_BYTE;
                r.byte_value = c.data;
                // drop the partial frame once the line has been idle too long
                if (frame_open && idle_count > timeout_cfg)
                begin
                    frame_open       = 1'b0;
                    frame_left       = 8'd0;
                    r.dropped_before = 1'b1;
                end
                idle_count = 16'd0;
                if (!frame_open)
                begin
                    r.first = 1'b1;
                    if (c.data == 8'd0)
                    begin
                        r.last = 1'b1;
                    end
                    else
                    begin
                        frame_left = c.data;
                        frame_open = 1'b1;
                    end
                end
                else
                begin
                    frame_left = frame_left - 8'd1;
                    if (frame_left == 8'd0)
                    begin
                        r.last     = 1'b1;
                        frame_open = 1'b0;
                    end
                end
                return 1'b1;
            end
            OP_TICK:
            begin
                if (idle_count != IDLE_MAX)
                begin
                    idle_count = idle_count + 16'd1;
                end
                return 1'b0;
            end
            OP_FLUSH:
            begin
                if (frame_open)
                begin
                    frame_open       = 1'b0;
                    frame_left       = 8'd0;
                    r.kind           = KIND_ABORT;
                    r.dropped_before = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_cfg = TIMEOUT_RESET;
            frame_left  = 8'd0;
            frame_open  = 1'b0;
            idle_count  = 16'd0;
            frame_res_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT)
            begin
                timeout_cfg = pwdata[15:0];
            end

            if (pop && !empty)
            begin
                got.kind           = kind;
                got.byte_value     = byte_value;
                got.first          = first;
                got.last           = last;
                got.dropped_before = dropped_before;
                if (frame_res_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %p", got));
                end
                else
                begin
                    want = frame_res_q.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %b, want %b", got.kind, want.kind));
                    if (got.byte_value !== want.byte_value)
                        report_mismatch($sformatf("byte_value %h, want %h",
                                                  got.byte_value, want.byte_value));
                    if (got.first !== want.first)
                        report_mismatch($sformatf("first %b, want %b", got.first, want.first));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                    if (got.dropped_before !== want.dropped_before)
                        report_mismatch($sformatf("dropped_before %b, want %b",
                                                  got.dropped_before, want.dropped_before));
                end
            end

            if (push && !full)
            begin
                req.op   = op;
                req.data = data;
                if (predict_deframe(req, predicted))
                begin
                    frame_res_q = {frame_res_q, predicted};
                end
            end
        end
        pending = frame_res_q.size();
    end

endmodule

### dv/tb_length_prefix_deframer_timeout_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer_timeout_core
// Drives byte, tick and flush requests into the deframer under several
// timeout settings and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_length_prefix_deframer_timeout_core;
    import lpd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        op = OP_TICK;
    logic [7:0]        data = 8'd0;
    logic              empty;
    logic              pop = 1'b0;
    logic              kind;
    logic [7:0]        byte_value;
    logic              first;
    logic              last;
    logic              dropped_before;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = ADDR_TIMEOUT;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatch_count;
    int                pending;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                requests_sent = 0;
    int                stall_cycles = 0;
    logic [15:0]       cur_timeout = TIMEOUT_RESET;

    always #2 clk = ~clk;

    length_prefix_deframer_timeout_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .data           (data),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .byte_value     (byte_value),
        .first          (first),
        .last           (last),
        .dropped_before (dropped_before),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    deframe_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .data           (data),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .byte_value     (byte_value),
        .first          (first),
        .last           (last),
        .dropped_before (dropped_before),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Result side: stall at random
    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Stop when nothing has moved on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] o, input logic [7:0] d);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        op   <= o;
        data <= d;
        do
        begin
            @(posedge clk);
        end
        while (full);
        if (o != OP_RSVD)
        begin
            requests_sent++;
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
        begin
            send_request(OP_TICK, 8'($urandom_range(255)));
        end
    endtask

    task automatic write_timeout(input logic [15:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIMEOUT;
        pwdata  <= {16'(~val), val} & 32'h0000_FFFF;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_timeout = val;
    endtask

    // Hold off until every result is out and the request queue has drained
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Well-formed frame with random content, idle gaps and the odd break
    task automatic send_random_frame();
        int len;
        int sel;
        int gap;
        int gap_max;
        gap_max = (cur_timeout > 16'd198) ? 200 : int'(cur_timeout) + 2;
        sel = $urandom_range(99);
        if (sel < 60)
            len = $urandom_range(6);
        else if (sel < 90)
            len = $urandom_range(31, 7);
        else
            len = $urandom_range(255);
        send_request(OP_BYTE, 8'(len));
        for (int n = 0; n < len; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 3)
            begin
                send_request(OP_FLUSH, 8'($urandom_range(255)));
                return;
            end
            // abandon: the next length byte lands inside this frame
            if (sel < 6)
            begin
                return;
            end
            if (sel < 76)
                gap = 0;
            else if (sel < 94)
                gap = $urandom_range(3, 1);
            else
                gap = $urandom_range(gap_max);
            send_ticks(gap);
            send_request(OP_BYTE, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int          target;
        logic [15:0] phase_timeout [6];
        int          phase_tx_pct [6];
        int          phase_rx_pct [6];

        phase_timeout = '{TIMEOUT_RESET, 16'd0, 16'd1, 16'($urandom_range(40, 2)),
                          16'd65534, 16'd65535};
        phase_tx_pct  = '{21, 21, 76, 76, 0, 0};
        phase_rx_pct  = '{76, 76, 21, 21, 0, 0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 6; p++)
        begin
            tx_idle_pct = phase_tx_pct[p];
            rx_idle_pct = phase_rx_pct[p];
            if (p > 0)
            begin
                write_timeout(phase_timeout[p]);
            end

            case (p)
                0:
                begin
                    // one-byte frame, idle flush, ignored opcode, full frames, abort
                    send_request(OP_BYTE, 8'd0);
                    send_request(OP_FLUSH, 8'hFF);
                    send_request(OP_RSVD, 8'hFF);
                    send_request(OP_BYTE, 8'd2);
                    send_request(OP_BYTE, 8'hFF);
                    send_request(OP_BYTE, 8'h00);
                    send_request(OP_BYTE, 8'd255);
                    send_request(OP_BYTE, 8'hAA);
                    send_request(OP_FLUSH, 8'h00);
                    send_request(OP_BYTE, 8'd1);
                    send_request(OP_BYTE, 8'h55);
                end
                1:
                begin
                    // zero timeout: back-to-back bytes survive, one tick drops
                    send_request(OP_BYTE, 8'd3);
                    send_request(OP_BYTE, 8'h11);
                    send_request(OP_TICK, 8'h00);
                    send_request(OP_BYTE, 8'd7);
                    send_request(OP_FLUSH, 8'h00);
                end
                2:
                begin
                    // timeout of one: equal count holds, one more drops
                    send_request(OP_TICK, 8'h00);
                    send_request(OP_BYTE, 8'd2);
                    send_request(OP_TICK, 8'h00);
                    send_request(OP_BYTE, 8'h80);
                    send_ticks(2);
                    send_request(OP_BYTE, 8'd0);
                end
                4:
                begin
                    send_request(OP_BYTE, 8'd5);
                    send_ticks(60);
                    send_request(OP_BYTE, 8'd1);
                    send_request(OP_BYTE, 8'h7F);
                end
                5:
                begin
                    // long idle gap stays far below the register: frame holds
                    send_request(OP_BYTE, 8'd2);
                    send_ticks(70);
                    send_request(OP_BYTE, 8'h01);
                    send_request(OP_BYTE, 8'hFE);
                end
                default:
                begin
                end
            endcase

            target = requests_sent + 280;
            while (requests_sent < target)
            begin
                if ($urandom_range(99) < 80)
                    send_random_frame();
                else
                    send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
            settle();
        end

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/lpd_pkg.sv
design/lpd_fifo.sv
design/lpd_front.sv
design/lpd_back.sv
design/length_prefix_deframer_timeout_core.sv
dv/deframe_checker.sv
dv/tb_length_prefix_deframer_timeout_core.sv
